// ===== rtl/core/blpg_pkg.sv =====
// shared types and constants of the bresenham line pixel generator
// no dependencies; imported by every module of the block

package blpg_pkg;

    // default coordinate width, overridable on the top level
    localparam int COORD_BITS_DEF = 12;

    // entries in the queue between front and back, power of two
    localparam int QUEUE_DEPTH = 4;

    // field widths fixed by the register map
    localparam int BPP_W   = 3;
    localparam int PITCH_W = 16;
    localparam int ADDR_W  = 32;
    localparam int COLOR_W = 32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COLOR     = 2'd3;

    // item kinds carried in tuser
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // per-axis step direction
    typedef enum logic [1:0] {
        DIR_HOLD = 2'b00,
        DIR_INC  = 2'b01,
        DIR_DEC  = 2'b11
    } t_dir;

    // configuration register file
    typedef struct packed {
        logic [BPP_W-1:0]   bytes_per_pixel;
        logic [PITCH_W-1:0] row_pitch;
        logic [ADDR_W-1:0]  frame_base;
        logic [COLOR_W-1:0] pixel_color;
    } t_cfg;

endpackage

// ===== rtl/core/bresenham_line_pixel_generator_top.sv =====
// top level of the bresenham line pixel generator: stream ports, config registers
// depends on blpg_pkg, blpg_front, blpg_queue, blpg_back

// Integer Bresenham line rasterizer with framebuffer addressing. A start
// transaction (tuser = 0) carries two endpoints and arms a line without
// producing output; each step transaction (tuser = 1) yields the next pixel
// with its coordinates, byte address (frame_base + y * row_pitch +
// x * bytes_per_pixel, modulo 2^32), the pen color cut to bytes_per_pixel low
// bytes, the byte count and tlast on the second endpoint. Both endpoints are
// drawn. A step with no line armed, or with a pixel size outside one to four,
// yields nothing (the latter still advances the line). Throughput is one
// transaction per clock, starts and steps alike, while the output side is not
// held: the back stage advances the error term, coordinates and row address
// together on each step, and the y * row_pitch product for a start is formed
// in the front. Input passes through the front register, the queue and the
// output register; a four-entry queue lets the front keep accepting while the
// output side is held. The user writes configuration through the plain write
// port only while the block is idle; the block itself does not enforce this.

module bresenham_line_pixel_generator_top #(
    parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = blpg_pkg::QUEUE_DEPTH
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // slave side
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // x_start, y_start, x_final, y_final, zero fill to whole bytes
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // mode
    input  logic                                    s_axis_tuser,
    // master side
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // pixel_x, pixel_y, byte_address, pixel_value, byte_count, zero fill
    output logic [((2*COORD_BITS+67+7)/8)*8-1:0]    m_axis_tdata,
    // last_pixel
    output logic                                    m_axis_tlast,
    // configuration write port
    input  logic                                    i_cfg_we,
    input  logic [blpg_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [blpg_pkg::CFG_DATA_W-1:0]         i_cfg_wdata
);
    import blpg_pkg::*;

    localparam int OUT_W   = ((2*COORD_BITS+67+7)/8)*8;
    localparam int OUT_USE = 2*COORD_BITS + ADDR_W + COLOR_W + BPP_W;
    // start flag, four coords, two doubled deltas, two step codes,
    // major-axis flag, error term, row offset
    localparam int ENTRY_W = 8*COORD_BITS + 27;

    // configuration registers
    t_cfg r_cfg, n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BYTES_PER_PIXEL: n_cfg.bytes_per_pixel = i_cfg_wdata[BPP_W-1:0];
                CFG_ROW_PITCH:       n_cfg.row_pitch       = i_cfg_wdata[PITCH_W-1:0];
                CFG_FRAME_BASE:      n_cfg.frame_base      = i_cfg_wdata[ADDR_W-1:0];
                CFG_PIXEL_COLOR:     n_cfg.pixel_color     = i_cfg_wdata[COLOR_W-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bytes_per_pixel <= BPP_W'(1);
            r_cfg.row_pitch       <= '0;
            r_cfg.frame_base      <= '0;
            r_cfg.pixel_color     <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // front stage outputs
    logic                          f_valid, f_ready;
    logic                          f_is_start;
    logic [COORD_BITS-1:0]         f_x_start, f_y_start, f_x_final, f_y_final;
    logic [COORD_BITS:0]           f_tadx, f_tady;
    t_dir                          f_step_x, f_step_y;
    logic                          f_x_major;
    logic signed [COORD_BITS+2:0]  f_err;
    logic [COORD_BITS+15:0]        f_row_offset;

    blpg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_mode         (s_axis_tuser),
        .i_x_start      (s_axis_tdata[COORD_BITS-1:0]),
        .i_y_start      (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_x_final      (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .i_y_final      (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .i_row_pitch    (r_cfg.row_pitch),
        .o_valid        (f_valid),
        .i_ready        (f_ready),
        .o_is_start     (f_is_start),
        .o_x_start      (f_x_start),
        .o_y_start      (f_y_start),
        .o_x_final      (f_x_final),
        .o_y_final      (f_y_final),
        .o_twice_abs_dx (f_tadx),
        .o_twice_abs_dy (f_tady),
        .o_step_x       (f_step_x),
        .o_step_y       (f_step_y),
        .o_x_major      (f_x_major),
        .o_error_init   (f_err),
        .o_row_offset   (f_row_offset)
    );

    // queue entry packing
    logic [ENTRY_W-1:0]            q_wdata, q_rdata;
    logic                          q_valid, q_ready;
    logic                          q_is_start;
    logic [COORD_BITS-1:0]         q_x_start, q_y_start, q_x_final, q_y_final;
    logic [COORD_BITS:0]           q_tadx, q_tady;
    logic [1:0]                    q_step_x_bits, q_step_y_bits;
    logic                          q_x_major;
    logic signed [COORD_BITS+2:0]  q_err;
    logic [COORD_BITS+15:0]        q_row_offset;

    assign q_wdata = {f_is_start, f_x_start, f_y_start, f_x_final, f_y_final,
                      f_tadx, f_tady, f_step_x, f_step_y, f_x_major, f_err,
                      f_row_offset};

    assign {q_is_start, q_x_start, q_y_start, q_x_final, q_y_final,
            q_tadx, q_tady, q_step_x_bits, q_step_y_bits, q_x_major, q_err,
            q_row_offset} = q_rdata;

    blpg_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (q_wdata),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_rdata)
    );

    // back stage outputs
    logic [COORD_BITS-1:0]  b_pixel_x, b_pixel_y;
    logic [ADDR_W-1:0]      b_byte_address;
    logic [COLOR_W-1:0]     b_pixel_value;
    logic [BPP_W-1:0]       b_byte_count;

    blpg_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (q_valid),
        .o_ready        (q_ready),
        .i_is_start     (q_is_start),
        .i_x_start      (q_x_start),
        .i_y_start      (q_y_start),
        .i_x_final      (q_x_final),
        .i_y_final      (q_y_final),
        .i_twice_abs_dx (q_tadx),
        .i_twice_abs_dy (q_tady),
        .i_step_x       (t_dir'(q_step_x_bits)),
        .i_step_y       (t_dir'(q_step_y_bits)),
        .i_x_major      (q_x_major),
        .i_error_init   (q_err),
        .i_row_offset   (q_row_offset),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_pixel_x      (b_pixel_x),
        .o_pixel_y      (b_pixel_y),
        .o_byte_address (b_byte_address),
        .o_pixel_value  (b_pixel_value),
        .o_byte_count   (b_byte_count),
        .o_last_pixel   (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_W-OUT_USE){1'b0}}, b_byte_count, b_pixel_value,
                           b_byte_address, b_pixel_y, b_pixel_x};

endmodule

// ===== rtl/core/blpg_front.sv =====
// front stage: accepts items, classifies start and step, sets up line parameters
// depends on blpg_pkg

module blpg_front #(
    parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic [COORD_BITS-1:0]         i_x_start,
    input  logic [COORD_BITS-1:0]         i_y_start,
    input  logic [COORD_BITS-1:0]         i_x_final,
    input  logic [COORD_BITS-1:0]         i_y_final,
    input  logic [blpg_pkg::PITCH_W-1:0]  i_row_pitch,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_is_start,
    output logic [COORD_BITS-1:0]         o_x_start,
    output logic [COORD_BITS-1:0]         o_y_start,
    output logic [COORD_BITS-1:0]         o_x_final,
    output logic [COORD_BITS-1:0]         o_y_final,
    output logic [COORD_BITS:0]           o_twice_abs_dx,
    output logic [COORD_BITS:0]           o_twice_abs_dy,
    output blpg_pkg::t_dir                o_step_x,
    output blpg_pkg::t_dir                o_step_y,
    output logic                          o_x_major,
    output logic signed [COORD_BITS+2:0]  o_error_init,
    output logic [COORD_BITS+15:0]        o_row_offset
);
    import blpg_pkg::*;

    logic                          r_valid;
    logic                          r_is_start;
    logic [COORD_BITS-1:0]         r_x_start, r_y_start, r_x_final, r_y_final;
    logic [COORD_BITS:0]           r_tadx, r_tady;
    t_dir                          r_step_x, r_step_y;
    logic                          r_x_major;
    logic signed [COORD_BITS+2:0]  r_err;
    logic [COORD_BITS+15:0]        r_row_offset;

    logic                          n_valid;
    logic                          load;
    logic signed [COORD_BITS:0]    d_x, d_y;
    logic [COORD_BITS-1:0]         abs_x, abs_y;
    logic [COORD_BITS:0]           n_tadx, n_tady;
    t_dir                          n_step_x, n_step_y;
    logic                          n_x_major;
    logic signed [COORD_BITS+2:0]  n_err;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        d_x = $signed({1'b0, i_x_final}) - $signed({1'b0, i_x_start});
        d_y = $signed({1'b0, i_y_final}) - $signed({1'b0, i_y_start});
        abs_x = d_x[COORD_BITS] ? COORD_BITS'(-d_x) : d_x[COORD_BITS-1:0];
        abs_y = d_y[COORD_BITS] ? COORD_BITS'(-d_y) : d_y[COORD_BITS-1:0];
        n_tadx = {abs_x, 1'b0};
        n_tady = {abs_y, 1'b0};
        n_x_major = abs_x > abs_y;
        // initial error: twice the minor delta less the major delta
        if (n_x_major) begin
            n_err = $signed({2'b00, n_tady}) - $signed({3'b000, abs_x});
        end else begin
            n_err = $signed({2'b00, n_tadx}) - $signed({3'b000, abs_y});
        end
        if (d_x[COORD_BITS]) begin
            n_step_x = DIR_DEC;
        end else if (abs_x == '0) begin
            n_step_x = DIR_HOLD;
        end else begin
            n_step_x = DIR_INC;
        end
        if (d_y[COORD_BITS]) begin
            n_step_y = DIR_DEC;
        end else if (abs_y == '0) begin
            n_step_y = DIR_HOLD;
        end else begin
            n_step_y = DIR_INC;
        end
        n_valid = load || (r_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_is_start   <= (i_mode == MODE_START);
            r_x_start    <= i_x_start;
            r_y_start    <= i_y_start;
            r_x_final    <= i_x_final;
            r_y_final    <= i_y_final;
            r_tadx       <= n_tadx;
            r_tady       <= n_tady;
            r_step_x     <= n_step_x;
            r_step_y     <= n_step_y;
            r_x_major    <= n_x_major;
            r_err        <= n_err;
            // start row offset, added to the frame base in the back
            r_row_offset <= i_y_start * i_row_pitch;
        end
    end

    assign o_valid        = r_valid;
    assign o_is_start     = r_is_start;
    assign o_x_start      = r_x_start;
    assign o_y_start      = r_y_start;
    assign o_x_final      = r_x_final;
    assign o_y_final      = r_y_final;
    assign o_twice_abs_dx = r_tadx;
    assign o_twice_abs_dy = r_tady;
    assign o_step_x       = r_step_x;
    assign o_step_y       = r_step_y;
    assign o_x_major      = r_x_major;
    assign o_error_init   = r_err;
    assign o_row_offset   = r_row_offset;

endmodule

// ===== rtl/core/blpg_queue.sv =====
// small first-in first-out queue of register entries between front and back
// depends on blpg_pkg

module blpg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = blpg_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    import blpg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             push, pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];

    // pointers wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/blpg_back.sv =====
// back stage: line state, bresenham stepping, address and color, output register
// depends on blpg_pkg

module blpg_back #(
    parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  blpg_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_is_start,
    input  logic [COORD_BITS-1:0]         i_x_start,
    input  logic [COORD_BITS-1:0]         i_y_start,
    input  logic [COORD_BITS-1:0]         i_x_final,
    input  logic [COORD_BITS-1:0]         i_y_final,
    input  logic [COORD_BITS:0]           i_twice_abs_dx,
    input  logic [COORD_BITS:0]           i_twice_abs_dy,
    input  blpg_pkg::t_dir                i_step_x,
    input  blpg_pkg::t_dir                i_step_y,
    input  logic                          i_x_major,
    input  logic signed [COORD_BITS+2:0]  i_error_init,
    input  logic [COORD_BITS+15:0]        i_row_offset,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [COORD_BITS-1:0]         o_pixel_x,
    output logic [COORD_BITS-1:0]         o_pixel_y,
    output logic [blpg_pkg::ADDR_W-1:0]   o_byte_address,
    output logic [blpg_pkg::COLOR_W-1:0]  o_pixel_value,
    output logic [blpg_pkg::BPP_W-1:0]    o_byte_count,
    output logic                          o_last_pixel
);
    import blpg_pkg::*;

    function automatic logic [COORD_BITS-1:0] step_coord(
        input logic [COORD_BITS-1:0] c,
        input t_dir                  d
    );
        logic [COORD_BITS-1:0] res;
        unique case (d)
            DIR_INC: res = c + COORD_BITS'(1);
            DIR_DEC: res = c - COORD_BITS'(1);
            default: res = c;
        endcase
        return res;
    endfunction

    // line state
    logic                          r_line_active, n_line_active;
    logic [COORD_BITS-1:0]         r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    logic [COORD_BITS-1:0]         r_end_x, n_end_x, r_end_y, n_end_y;
    logic signed [COORD_BITS+2:0]  r_err, n_err;
    logic [COORD_BITS:0]           r_tadx, n_tadx, r_tady, n_tady;
    t_dir                          r_step_x, n_step_x, r_step_y, n_step_y;
    logic                          r_x_major, n_x_major;
    logic [ADDR_W-1:0]             r_row_addr, n_row_addr;

    // output register
    logic                          r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0]         r_pixel_x, n_pixel_x, r_pixel_y, n_pixel_y;
    logic [ADDR_W-1:0]             r_byte_address, n_byte_address;
    logic [COLOR_W-1:0]            r_pixel_value, n_pixel_value;
    logic [BPP_W-1:0]              r_byte_count, n_byte_count;
    logic                          r_last_pixel, n_last_pixel;

    logic                          pop;
    logic                          is_last;
    logic                          err_nonneg;
    logic                          move_x, move_y;
    logic                          emit;
    logic signed [COORD_BITS+2:0]  tadx_s, tady_s;
    logic [ADDR_W-1:0]             x_wide, x_bytes, pitch_wide;
    logic [COLOR_W-1:0]            color_mask;

    assign o_ready = !r_out_valid || i_ready;
    assign pop     = i_valid && o_ready;

    always_comb begin
        is_last    = r_x_major ? (r_cur_x == r_end_x) : (r_cur_y == r_end_y);
        err_nonneg = !r_err[COORD_BITS+2];
        move_x     = !is_last && (r_x_major || err_nonneg);
        move_y     = !is_last && (!r_x_major || err_nonneg);
        tadx_s     = $signed({2'b00, r_tadx});
        tady_s     = $signed({2'b00, r_tady});
        emit       = (i_cfg.bytes_per_pixel != '0) && (i_cfg.bytes_per_pixel <= BPP_W'(4));
        x_wide     = ADDR_W'(r_cur_x);
        pitch_wide = ADDR_W'(i_cfg.row_pitch);

        // x times the pixel size by shift and add
        unique case (i_cfg.bytes_per_pixel)
            3'd1:    x_bytes = x_wide;
            3'd2:    x_bytes = x_wide << 1;
            3'd3:    x_bytes = (x_wide << 1) + x_wide;
            3'd4:    x_bytes = x_wide << 2;
            default: x_bytes = '0;
        endcase
        unique case (i_cfg.bytes_per_pixel)
            3'd1:    color_mask = 32'h0000_00FF;
            3'd2:    color_mask = 32'h0000_FFFF;
            3'd3:    color_mask = 32'h00FF_FFFF;
            default: color_mask = 32'hFFFF_FFFF;
        endcase

        n_line_active  = r_line_active;
        n_cur_x        = r_cur_x;
        n_cur_y        = r_cur_y;
        n_end_x        = r_end_x;
        n_end_y        = r_end_y;
        n_err          = r_err;
        n_tadx         = r_tadx;
        n_tady         = r_tady;
        n_step_x       = r_step_x;
        n_step_y       = r_step_y;
        n_x_major      = r_x_major;
        n_row_addr     = r_row_addr;
        n_out_valid    = r_out_valid && !i_ready;
        n_pixel_x      = r_pixel_x;
        n_pixel_y      = r_pixel_y;
        n_byte_address = r_byte_address;
        n_pixel_value  = r_pixel_value;
        n_byte_count   = r_byte_count;
        n_last_pixel   = r_last_pixel;

        if (pop) begin
            if (i_is_start) begin
                // arm a new line, abandoning any line in progress
                n_line_active = 1'b1;
                n_cur_x       = i_x_start;
                n_cur_y       = i_y_start;
                n_end_x       = i_x_final;
                n_end_y       = i_y_final;
                n_err         = i_error_init;
                n_tadx        = i_twice_abs_dx;
                n_tady        = i_twice_abs_dy;
                n_step_x      = i_step_x;
                n_step_y      = i_step_y;
                n_x_major     = i_x_major;
                n_row_addr    = i_cfg.frame_base + ADDR_W'(i_row_offset);
            end else if (r_line_active) begin
                n_line_active = !is_last;
                if (move_x) begin
                    n_cur_x = step_coord(r_cur_x, r_step_x);
                end
                if (move_y) begin
                    n_cur_y = step_coord(r_cur_y, r_step_y);
                    unique case (r_step_y)
                        DIR_INC: n_row_addr = r_row_addr + pitch_wide;
                        DIR_DEC: n_row_addr = r_row_addr - pitch_wide;
                        default: n_row_addr = r_row_addr;
                    endcase
                end
                if (!is_last) begin
                    if (r_x_major) begin
                        n_err = r_err - (err_nonneg ? tadx_s : '0) + tady_s;
                    end else begin
                        n_err = r_err - (err_nonneg ? tady_s : '0) + tadx_s;
                    end
                end
                if (emit) begin
                    n_out_valid    = 1'b1;
                    n_pixel_x      = r_cur_x;
                    n_pixel_y      = r_cur_y;
                    n_byte_address = r_row_addr + x_bytes;
                    n_pixel_value  = i_cfg.pixel_color & color_mask;
                    n_byte_count   = i_cfg.bytes_per_pixel;
                    n_last_pixel   = is_last;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_line_active <= n_line_active;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x        <= n_cur_x;
        r_cur_y        <= n_cur_y;
        r_end_x        <= n_end_x;
        r_end_y        <= n_end_y;
        r_err          <= n_err;
        r_tadx         <= n_tadx;
        r_tady         <= n_tady;
        r_step_x       <= n_step_x;
        r_step_y       <= n_step_y;
        r_x_major      <= n_x_major;
        r_row_addr     <= n_row_addr;
        r_pixel_x      <= n_pixel_x;
        r_pixel_y      <= n_pixel_y;
        r_byte_address <= n_byte_address;
        r_pixel_value  <= n_pixel_value;
        r_byte_count   <= n_byte_count;
        r_last_pixel   <= n_last_pixel;
    end

    assign o_valid        = r_out_valid;
    assign o_pixel_x      = r_pixel_x;
    assign o_pixel_y      = r_pixel_y;
    assign o_byte_address = r_byte_address;
    assign o_pixel_value  = r_pixel_value;
    assign o_byte_count   = r_byte_count;
    assign o_last_pixel   = r_last_pixel;

endmodule
